// ===== rtl/core/tprc_pkg.sv =====
// Package for the typed packet receiver: codes, register indexes, reset values
// and the records that pass between the front end, the queue and the back end.
// No dependencies.
package tprc_pkg;

  // Upper end of the MAX_PACKET range; sizes the count field of a descriptor
  localparam int MAX_PACKET_LIMIT = 64;
  localparam int CNT_W = $clog2(MAX_PACKET_LIMIT + 1);

  localparam int NUM_TYPES = 7;
  localparam int LEN_W = 5;
  localparam int IDX_W = 5;
  localparam int TIMEOUT_W = 16;

  localparam logic [7:0] START_MARK = 8'h21;  // '!'

  // Type letters in register order: A G M Q B C L
  localparam logic [NUM_TYPES-1:0][7:0] TYPE_LETTER = {
    8'h4C, 8'h43, 8'h42, 8'h51, 8'h4D, 8'h47, 8'h41
  };

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd500;
  localparam logic [NUM_TYPES-1:0][LEN_W-1:0] LEN_RESET = {
    5'd15, 5'd6, 5'd5, 5'd19, 5'd15, 5'd15, 5'd15
  };

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  typedef enum logic [1:0] {
    ST_GOOD    = 2'd0,
    ST_CSUM    = 2'd1,
    ST_TIMEOUT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_TIMEOUT        = 3'd0,
    REG_LEN_ACCEL      = 3'd1,
    REG_LEN_GYRO       = 3'd2,
    REG_LEN_MAGNET     = 3'd3,
    REG_LEN_QUATERNION = 3'd4,
    REG_LEN_BUTTON     = 3'd5,
    REG_LEN_COLOUR     = 3'd6,
    REG_LEN_LOCATION   = 3'd7
  } reg_idx_t;

  // One finished packet or event, as queued between front and back
  typedef struct packed {
    status_t          status;
    logic [CNT_W-1:0] count;  // good: bytes to emit; else the reported index
    logic [7:0]       ptype;
    logic             bank;
  } desc_t;

  // Back end hands a drained buffer bank back to the front end
  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  typedef struct packed {
    status_t          status;
    logic [7:0]       data;
    logic [IDX_W-1:0] index;
    logic [7:0]       ptype;
    logic             last;
  } result_t;

endpackage

// ===== rtl/core/tprc_if.sv =====
// Channel interfaces of the typed packet receiver: input items, results and
// configuration writes. No dependencies.
interface tprc_item_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] rx_byte;
  modport source(output valid, kind, rx_byte, input ready);
  modport sink(input valid, kind, rx_byte, output ready);
endinterface

interface tprc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] data_byte;
  logic [4:0] byte_index;
  logic [7:0] packet_type;
  logic       is_last;
  modport source(output valid, status, data_byte, byte_index, packet_type, is_last,
                 input ready);
  modport sink(input valid, status, data_byte, byte_index, packet_type, is_last,
               output ready);
endinterface

interface tprc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/tprc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module tprc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tprc_queue.sv =====
// Two-entry queue of packet descriptors between front and back end.
// Depends on nothing but its width parameter.
module tprc_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  output logic         valid,
  output logic [W-1:0] dout,
  input  logic         pop
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign dout  = mem[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= ~wptr;
      if (pop) rptr <= ~rptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (!full || pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> valid)
    else $error("queue pop while empty");
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not advance");
`endif

endmodule

// ===== rtl/core/tprc_front.sv =====
// Front end: configuration registers, packet framing, running checksum, idle
// timeout; writes bytes to the RAM, queues descriptors. Uses tprc_pkg and tprc_if.
module tprc_front
  import tprc_pkg::*;
#(
  parameter int MAX_PACKET = 20,
  localparam int IW = $clog2(MAX_PACKET),
  localparam int CW = $clog2(MAX_PACKET + 1),
  localparam int CMP_W = (CW > LEN_W) ? CW : LEN_W
) (
  input  logic            clk,
  input  logic            rst,
  tprc_item_if.sink       items,
  tprc_cfg_if.sink        cfg,
  output logic            wr_en,
  output logic [IW:0]     wr_addr,
  output logic [7:0]      wr_data,
  output logic            q_push,
  output desc_t           q_desc,
  input  logic            q_full,
  input  rel_t            rel
);

  logic [TIMEOUT_W-1:0]             timeout_ticks;
  logic [NUM_TYPES-1:0][LEN_W-1:0]  type_len;

  logic [CW-1:0]        byte_count, byte_count_next;
  logic [7:0]           running_sum, running_sum_next;
  logic                 in_packet, in_packet_next;
  logic [TIMEOUT_W-1:0] idle_ticks, idle_ticks_next;
  logic [7:0]           type_reg, type_reg_next;
  logic                 wbank, wbank_next;
  logic [1:0]           busy, busy_next;

  logic                 accept;
  logic [IW-1:0]        wr_idx;
  logic [CW-1:0]        n;
  logic [7:0]           type_now;
  logic                 len_hit;
  logic [TIMEOUT_W-1:0] idle_inc;

  assign items.ready = !q_full && !busy[wbank];
  assign accept      = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  assign wr_addr = {wbank, wr_idx};
  assign wr_data = items.rx_byte;

  // Byte count after storing this byte, and type byte as it stands then
  assign n        = byte_count + CW'(1);
  assign type_now = (byte_count == CW'(1)) ? items.rx_byte : type_reg;
  assign idle_inc = (idle_ticks == '1) ? idle_ticks : idle_ticks + TIMEOUT_W'(1);

  always_comb begin
    len_hit = 1'b0;
    for (int t = 0; t < NUM_TYPES; t++) begin
      if (type_now == TYPE_LETTER[t] && CMP_W'(n) == CMP_W'(type_len[t])) begin
        len_hit = 1'b1;
      end
    end
  end

  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    in_packet_next   = in_packet;
    idle_ticks_next  = idle_ticks;
    type_reg_next    = type_reg;
    wbank_next       = wbank;
    busy_next        = busy;
    wr_en            = 1'b0;
    wr_idx           = '0;
    q_push           = 1'b0;
    q_desc           = '0;
    if (rel.valid) begin
      busy_next[rel.bank] = 1'b0;
    end
    if (accept) begin
      if (items.kind == KIND_BYTE) begin
        idle_ticks_next = '0;
        if (items.rx_byte == START_MARK) begin
          wr_en            = 1'b1;
          byte_count_next  = CW'(1);
          running_sum_next = START_MARK;
          in_packet_next   = 1'b1;
        end else if (in_packet) begin
          wr_en            = 1'b1;
          wr_idx           = byte_count[IW-1:0];
          byte_count_next  = n;
          running_sum_next = running_sum + items.rx_byte;
          type_reg_next    = type_now;
          if (n == CW'(MAX_PACKET) || len_hit) begin
            q_push       = 1'b1;
            q_desc.ptype = type_now;
            q_desc.bank  = wbank;
            if (~running_sum == items.rx_byte) begin
              q_desc.status   = ST_GOOD;
              q_desc.count    = CNT_W'(n);
              wbank_next      = ~wbank;
              busy_next[wbank] = 1'b1;
            end else begin
              q_desc.status = ST_CSUM;
              q_desc.count  = CNT_W'(byte_count);
            end
            byte_count_next  = '0;
            running_sum_next = '0;
            in_packet_next   = 1'b0;
          end
        end
      end else if (in_packet) begin
        idle_ticks_next = idle_inc;
        if (idle_inc > timeout_ticks) begin
          q_push           = 1'b1;
          q_desc.status    = ST_TIMEOUT;
          q_desc.count     = CNT_W'(byte_count);
          q_desc.ptype     = (byte_count >= CW'(2)) ? type_reg : 8'd0;
          q_desc.bank      = wbank;
          byte_count_next  = '0;
          running_sum_next = '0;
          in_packet_next   = 1'b0;
          idle_ticks_next  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      in_packet   <= 1'b0;
      idle_ticks  <= '0;
      wbank       <= 1'b0;
      busy        <= '0;
    end else begin
      byte_count  <= byte_count_next;
      running_sum <= running_sum_next;
      in_packet   <= in_packet_next;
      idle_ticks  <= idle_ticks_next;
      wbank       <= wbank_next;
      busy        <= busy_next;
    end
  end

  always_ff @(posedge clk) begin
    type_reg <= type_reg_next;
  end

  // Register file
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      type_len      <= LEN_RESET;
    end else if (cfg.valid) begin
      unique case (reg_idx_t'(cfg.index))
        REG_TIMEOUT:        timeout_ticks <= cfg.data;
        REG_LEN_ACCEL:      type_len[0]   <= cfg.data[LEN_W-1:0];
        REG_LEN_GYRO:       type_len[1]   <= cfg.data[LEN_W-1:0];
        REG_LEN_MAGNET:     type_len[2]   <= cfg.data[LEN_W-1:0];
        REG_LEN_QUATERNION: type_len[3]   <= cfg.data[LEN_W-1:0];
        REG_LEN_BUTTON:     type_len[4]   <= cfg.data[LEN_W-1:0];
        REG_LEN_COLOUR:     type_len[5]   <= cfg.data[LEN_W-1:0];
        REG_LEN_LOCATION:   type_len[6]   <= cfg.data[LEN_W-1:0];
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count < CW'(MAX_PACKET))
    else $error("byte count reached packet limit without completing");
  a_write_free_bank: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> !busy[wbank])
    else $error("write into a bank still being drained");
  a_closed_clean: assert property (@(posedge clk) disable iff (rst)
    !in_packet |-> (byte_count == '0 && idle_ticks == '0))
    else $error("closed packet left state behind");
  a_release_busy: assert property (@(posedge clk) disable iff (rst)
    rel.valid |-> busy[rel.bank])
    else $error("release of a bank that was not busy");
`endif

endmodule

// ===== rtl/core/tprc_back.sv =====
// Back end: walks queued descriptors, reads good packets out of the buffer RAM
// and feeds a two-entry result buffer. Uses tprc_pkg and tprc_if.
module tprc_back
  import tprc_pkg::*;
#(
  parameter int MAX_PACKET = 20,
  localparam int IW = $clog2(MAX_PACKET)
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  desc_t        q_desc,
  output logic         q_pop,
  output logic         rd_en,
  output logic [IW:0]  rd_addr,
  input  logic [7:0]   rd_data,
  output rel_t         rel,
  tprc_result_if.source results
);

  logic [IW-1:0] pos;
  logic          inflight;
  result_t       meta;       // result in flight, data filled from the RAM
  logic          meta_ram;
  result_t       obuf [2];
  logic          owptr, orptr;
  logic [1:0]    ocount;

  logic          pop_out;
  logic [1:0]    used;
  logic          issue;
  logic          is_good;
  logic          at_last;
  result_t       head;
  result_t       fill;

  assign head = obuf[orptr];
  assign results.valid       = (ocount != 2'd0);
  assign results.status      = head.status;
  assign results.data_byte   = head.data;
  assign results.byte_index  = head.index;
  assign results.packet_type = head.ptype;
  assign results.is_last     = head.last;

  assign pop_out = results.valid && results.ready;
  assign used    = ocount + {1'b0, inflight};
  assign issue   = q_valid && (used < 2'd2 || pop_out);
  assign is_good = (q_desc.status == ST_GOOD);
  assign at_last = (CNT_W'(pos) == q_desc.count - CNT_W'(1));

  assign rd_en     = issue && is_good;
  assign rd_addr   = {q_desc.bank, pos};
  assign q_pop     = issue && (!is_good || at_last);
  assign rel.valid = issue && is_good && at_last;
  assign rel.bank  = q_desc.bank;

  always_comb begin
    fill = meta;
    if (!meta_ram) begin
      fill.data = 8'd0;
    end else begin
      fill.data = rd_data;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      meta.status <= q_desc.status;
      meta.data   <= 8'd0;
      meta.ptype  <= q_desc.ptype;
      meta_ram    <= is_good;
      if (is_good) begin
        meta.index <= IDX_W'(pos);
        meta.last  <= at_last;
      end else begin
        meta.index <= IDX_W'(q_desc.count);
        meta.last  <= 1'b1;
      end
    end
    if (inflight) begin
      obuf[owptr] <= fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      inflight <= 1'b0;
      owptr    <= 1'b0;
      orptr    <= 1'b0;
      ocount   <= 2'd0;
    end else begin
      inflight <= issue;
      if (issue && is_good) begin
        pos <= at_last ? '0 : pos + IW'(1);
      end
      if (inflight) owptr <= ~owptr;
      if (pop_out) orptr <= ~orptr;
      ocount <= ocount + {1'b0, inflight} - {1'b0, pop_out};
    end
  end

`ifndef SYNTHESIS
  a_buffer_room: assert property (@(posedge clk) disable iff (rst)
    (ocount + {1'b0, inflight}) <= 2'd2)
    else $error("result buffer overcommitted");
  a_drain_holds_head: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) |-> (q_valid && q_desc.status == ST_GOOD))
    else $error("packet drain lost its descriptor");
  a_pos_in_packet: assert property (@(posedge clk) disable iff (rst)
    (pos != '0) |-> (CNT_W'(pos) < q_desc.count))
    else $error("drain position past packet end");
`endif

endmodule

// ===== rtl/core/typed_packet_receiver_checksum_top.sv =====
// Top level of the typed packet receiver with inverted-sum checksum.
// Uses tprc_pkg, tprc_if, tprc_ram, tprc_queue, tprc_front and tprc_back.
//
// Channels (valid/ready, a transfer when both are high at a rising edge):
//   items   - one item per transfer: kind 0 is a received byte, kind 1 a tick.
//   results - good packet bytes (status 0), checksum errors (status 1) and
//             timeout discards (status 2); is_last closes each item's results.
//   cfg     - register writes: index 0 timeout, 1..7 type lengths A G M Q B C L.
//             Always ready; write only while the block is idle.
// Throughput: one item per cycle unless items is back-pressured. A good packet
// drains at one result per cycle unless the receiver stalls; the first result
// of any item is registered in the queue, the read stage and the result buffer.
// Packet bytes land in two RAM banks; while both banks hold packets waiting
// to drain, items stalls until the back end frees one. The two-entry
// descriptor queue also back-pressures items when full.
// Receiver stall: the result buffer holds its head; the back end stops
// issuing reads, the queue fills, then items.ready drops. Nothing is lost.
// Reset (rst, synchronous): no packet open, sums and counts cleared, queue
// and result buffer empty, registers at their reset values. The RAM is not
// cleared; only bytes of the current packet are ever read.
module typed_packet_receiver_checksum_top
  import tprc_pkg::*;
#(
  parameter int MAX_PACKET = 20
) (
  input  logic           clk,
  input  logic           rst,
  tprc_item_if.sink      items,
  tprc_cfg_if.sink       cfg,
  tprc_result_if.source  results
);

  localparam int IW = $clog2(MAX_PACKET);
  localparam int RAM_DEPTH = 2 ** (IW + 1);  // two banks of packet bytes

  logic        wr_en;
  logic [IW:0] wr_addr;
  logic [7:0]  wr_data;
  logic        rd_en;
  logic [IW:0] rd_addr;
  logic [7:0]  rd_data;

  logic        q_push;
  desc_t       q_din;
  logic        q_full;
  logic        q_valid;
  logic [$bits(desc_t)-1:0] q_dout;
  logic        q_pop;
  rel_t        rel;

  // Classifies items, tracks the open packet, owns the registers
  tprc_front #(.MAX_PACKET(MAX_PACKET)) u_front (
    .clk     (clk),
    .rst     (rst),
    .items   (items),
    .cfg     (cfg),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .q_push  (q_push),
    .q_desc  (q_din),
    .q_full  (q_full),
    .rel     (rel)
  );

  // Packet byte store, bank select in the top address bit
  tprc_ram #(.WIDTH(8), .DEPTH(RAM_DEPTH)) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Finished packets and events waiting for the back end
  tprc_queue #(.W($bits(desc_t))) u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .valid (q_valid),
    .dout  (q_dout),
    .pop   (q_pop)
  );

  // Turns descriptors into result transfers
  tprc_back #(.MAX_PACKET(MAX_PACKET)) u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_desc  (desc_t'(q_dout)),
    .q_pop   (q_pop),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .rel     (rel),
    .results (results)
  );

`ifndef SYNTHESIS
  a_param_range: assert property (@(posedge clk)
    (MAX_PACKET >= 4 && MAX_PACKET <= MAX_PACKET_LIMIT))
    else $error("MAX_PACKET out of range");
  a_no_read_write_clash: assert property (@(posedge clk) disable iff (rst)
    (wr_en && rd_en) |-> (wr_addr[IW] != rd_addr[IW]))
    else $error("front and back end in the same bank");
  a_good_byte_is_data: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.status != ST_GOOD) |-> (results.is_last
      && results.data_byte == 8'd0))
    else $error("error result not a single zero-data transfer");
`endif

endmodule
